// File: sv/bbc_pkg.sv
// Package for the bracket balance checker: payload structs, queue entry,
// stack sizing constants and character codes.
// No dependencies; every other file of the block uses it.
package bbc_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_OPEN_RND = 8'h28;
    localparam logic [7:0] CH_OPEN_CRL = 8'h7B;
    localparam logic [7:0] CH_OPEN_SQR = 8'h5B;
    localparam logic [7:0] CH_CLOS_RND = 8'h29;
    localparam logic [7:0] CH_CLOS_CRL = 8'h7D;
    localparam logic [7:0] CH_CLOS_SQR = 8'h5D;

    localparam logic [1:0] BR_ROUND  = 2'd0;
    localparam logic [1:0] BR_CURLY  = 2'd1;
    localparam logic [1:0] BR_SQUARE = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } bbc_op_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_byte;
    } bbc_in_t;

    typedef struct packed {
        logic text_valid;
        logic depth_overflow;
    } bbc_out_t;

    // One classified byte as it travels from the front to the back.
    typedef struct packed {
        bbc_op_t    op;
        logic [1:0] code;
        logic       last;
    } bbc_entry_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               mismatch;
        logic               overflow;
    } bbc_status_t;

endpackage

// File: sv/bbc_front.sv
// Front end of the bracket balance checker: comment state machine and
// classification of each accepted byte into a stack operation.
// Depends on bbc_pkg.
module bbc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bbc_pkg::bbc_in_t    in_data,
    input  logic                q_full,
    output logic                full,
    output logic                enq,
    output bbc_pkg::bbc_entry_t enq_data
);

    typedef enum logic [4:0] {
        CS_NORMAL     = 5'b00001,
        CS_SLASH      = 5'b00010,
        CS_LINE       = 5'b00100,
        CS_BLOCK      = 5'b01000,
        CS_BLOCK_STAR = 5'b10000
    } cs_state_t;

    cs_state_t           state_reg;
    cs_state_t           state_next;
    logic                is_code;
    bbc_pkg::bbc_entry_t cls;
    logic [7:0]          c;

    assign c    = in_data.char_code;
    assign full = q_full;
    assign enq  = push && !q_full;

    // Bracket decode of a byte that reaches normal code.
    always_comb
    begin
        cls.op   = bbc_pkg::OP_NONE;
        cls.code = bbc_pkg::BR_ROUND;
        cls.last = in_data.last_byte;
        case (c)
            bbc_pkg::CH_OPEN_RND:
            begin
                cls.op   = bbc_pkg::OP_PUSH;
                cls.code = bbc_pkg::BR_ROUND;
            end
            bbc_pkg::CH_OPEN_CRL:
            begin
                cls.op   = bbc_pkg::OP_PUSH;
                cls.code = bbc_pkg::BR_CURLY;
            end
            bbc_pkg::CH_OPEN_SQR:
            begin
                cls.op   = bbc_pkg::OP_PUSH;
                cls.code = bbc_pkg::BR_SQUARE;
            end
            bbc_pkg::CH_CLOS_RND:
            begin
                cls.op   = bbc_pkg::OP_POP;
                cls.code = bbc_pkg::BR_ROUND;
            end
            bbc_pkg::CH_CLOS_CRL:
            begin
                cls.op   = bbc_pkg::OP_POP;
                cls.code = bbc_pkg::BR_CURLY;
            end
            bbc_pkg::CH_CLOS_SQR:
            begin
                cls.op   = bbc_pkg::OP_POP;
                cls.code = bbc_pkg::BR_SQUARE;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        is_code    = 1'b0;
        case (state_reg)
            CS_NORMAL:
            begin
                if (c == bbc_pkg::CH_SLASH) state_next = CS_SLASH;
                else                        is_code    = 1'b1;
            end
            CS_SLASH:
            begin
                if (c == bbc_pkg::CH_SLASH)     state_next = CS_LINE;
                else if (c == bbc_pkg::CH_STAR) state_next = CS_BLOCK;
                else
                begin
                    // A lone slash was nothing; this byte is ordinary code.
                    state_next = CS_NORMAL;
                    is_code    = 1'b1;
                end
            end
            CS_LINE:
            begin
                if (c == bbc_pkg::CH_NEWLINE) state_next = CS_NORMAL;
            end
            CS_BLOCK:
            begin
                if (c == bbc_pkg::CH_STAR) state_next = CS_BLOCK_STAR;
            end
            CS_BLOCK_STAR:
            begin
                if (c == bbc_pkg::CH_SLASH)     state_next = CS_NORMAL;
                else if (c != bbc_pkg::CH_STAR) state_next = CS_BLOCK;
            end
            default:
            begin
                state_next = CS_NORMAL;
                is_code    = 1'b1;
            end
        endcase
        if (in_data.last_byte) state_next = CS_NORMAL;
    end

    always_comb
    begin
        enq_data    = cls;
        if (!is_code) enq_data.op = bbc_pkg::OP_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)   state_reg <= CS_NORMAL;
        else if (enq) state_reg <= state_next;
    end

endmodule

// File: sv/bbc_fifo.sv
// Short queue of classified beats between the front and the back end.
// Depends on bbc_pkg.
module bbc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  bbc_pkg::bbc_entry_t wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output logic                rd_valid,
    output bbc_pkg::bbc_entry_t rd_data
);

    bbc_pkg::bbc_entry_t                   slot_reg [bbc_pkg::QUEUE_DEPTH];
    logic [bbc_pkg::QPTR_W-1:0]            wr_ptr_reg;
    logic [bbc_pkg::QPTR_W-1:0]            rd_ptr_reg;
    logic [bbc_pkg::QCNT_W-1:0]            count_reg;
    logic                                  do_wr;
    logic                                  do_rd;

    assign q_full   = (count_reg == bbc_pkg::QCNT_W'(bbc_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !q_full;
    assign do_rd    = rd_en && rd_valid;

    always_ff @(posedge clk)
    begin
        if (do_wr) slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                if (wr_ptr_reg == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) wr_ptr_reg <= '0;
                else wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                if (rd_ptr_reg == bbc_pkg::QPTR_W'(bbc_pkg::QUEUE_DEPTH - 1)) rd_ptr_reg <= '0;
                else rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)      count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: sv/bbc_back.sv
// Back end of the bracket balance checker: bracket stack with the top two
// entries in registers, sticky error flags and the result register.
// Depends on bbc_pkg.
module bbc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  bbc_pkg::bbc_entry_t  item,
    output logic                 item_take,
    output logic                 empty,
    input  logic                 pop,
    output bbc_pkg::bbc_out_t    out_data,
    output bbc_pkg::bbc_status_t status
);

    localparam logic [bbc_pkg::LEVEL_W-1:0] FULL_LEVEL = bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH);

    logic [1:0]                  mem [bbc_pkg::STACK_DEPTH];
    logic [1:0]                  tos_reg;
    logic [1:0]                  below_reg;
    logic [bbc_pkg::LEVEL_W-1:0] level_reg;
    logic [bbc_pkg::LEVEL_W-1:0] level_next;
    logic                        mismatch_reg;
    logic                        mismatch_next;
    logic                        overflow_reg;
    logic                        overflow_next;
    logic                        out_valid_reg;
    bbc_pkg::bbc_out_t           out_data_reg;
    logic                        err;
    logic                        do_push;
    logic                        do_pop;
    logic                        mem_we;
    logic [bbc_pkg::LEVEL_W-1:0] lvl_m1;
    logic [bbc_pkg::LEVEL_W-1:0] lvl_m3;
    logic [bbc_pkg::ADDR_W-1:0]  wr_addr;
    logic [bbc_pkg::ADDR_W-1:0]  rd_addr;
    logic                        out_done;

    // A last beat waits only while an unread result still sits in the register.
    assign out_done  = pop && out_valid_reg;
    assign item_take = item_valid && !(item.last && out_valid_reg && !pop);
    assign empty     = !out_valid_reg;
    assign out_data  = out_data_reg;

    assign err     = mismatch_reg || overflow_reg;
    assign do_push = item_take && (item.op == bbc_pkg::OP_PUSH) && !err && (level_reg != FULL_LEVEL);
    assign do_pop  = item_take && (item.op == bbc_pkg::OP_POP) && !err && (level_reg != '0);
    assign mem_we  = do_push && (level_reg != '0);

    // The top entry lives in tos_reg and the one below in below_reg; the memory
    // holds the deeper entries and prefetches the next one down on each pop.
    assign lvl_m1  = level_reg - bbc_pkg::LEVEL_W'(1);
    assign lvl_m3  = level_reg - bbc_pkg::LEVEL_W'(3);
    assign wr_addr = lvl_m1[bbc_pkg::ADDR_W-1:0];
    assign rd_addr = lvl_m3[bbc_pkg::ADDR_W-1:0];

    always_comb
    begin
        level_next    = level_reg;
        mismatch_next = mismatch_reg;
        overflow_next = overflow_reg;
        if (item_take && !err)
        begin
            case (item.op)
                bbc_pkg::OP_PUSH:
                begin
                    if (level_reg == FULL_LEVEL) overflow_next = 1'b1;
                    else                         level_next    = level_reg + 1'b1;
                end
                bbc_pkg::OP_POP:
                begin
                    if (level_reg == '0) mismatch_next = 1'b1;
                    else
                    begin
                        level_next = lvl_m1;
                        if (tos_reg != item.code) mismatch_next = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) mem[wr_addr] <= tos_reg;
        if (do_push)
        begin
            tos_reg   <= item.code;
            below_reg <= tos_reg;
        end
        else if (do_pop)
        begin
            tos_reg   <= below_reg;
            below_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && item.last)
        begin
            out_data_reg.text_valid     <= !mismatch_next && !overflow_next && (level_next == '0);
            out_data_reg.depth_overflow <= overflow_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            mismatch_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take && item.last)
            begin
                level_reg    <= '0;
                mismatch_reg <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                level_reg    <= level_next;
                mismatch_reg <= mismatch_next;
                overflow_reg <= overflow_next;
            end
            if (item_take && item.last) out_valid_reg <= 1'b1;
            else if (out_done)          out_valid_reg <= 1'b0;
        end
    end

    assign status.level    = level_reg;
    assign status.mismatch = mismatch_reg;
    assign status.overflow = overflow_reg;

endmodule

// File: sv/bracket_balance_checker_unit.sv
// Top level of the bracket balance checker: front end, beat queue, back end.
// Depends on bbc_pkg, bbc_front, bbc_fifo and bbc_back.
//
// The block takes one byte of text per clock while full is low, and checks
// that (), {} and [] nest and match, skipping line comments and block
// comments. Each byte becomes a push, a pop or nothing on a stack of
// bbc_pkg::STACK_DEPTH entries whose top two entries sit in registers, with
// the memory read one entry deeper ahead of time, so pushes and pops sustain
// one byte per cycle. A result is registered on the output ports when the
// back end takes the byte marked last from the queue; a later last byte
// waits in the two-entry queue only while the previous result has not been
// popped. The stack memory needs no clearing after reset or between texts.
module bracket_balance_checker_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  bbc_pkg::bbc_in_t  in_data,
    output logic              empty,
    input  logic              pop,
    output bbc_pkg::bbc_out_t out_data
);

    logic                 q_full;
    logic                 enq;
    bbc_pkg::bbc_entry_t  enq_data;
    logic                 q_valid;
    bbc_pkg::bbc_entry_t  q_data;
    logic                 q_take;
    bbc_pkg::bbc_status_t status;

    bbc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_data  (in_data),
        .q_full   (q_full),
        .full     (full),
        .enq      (enq),
        .enq_data (enq_data)
    );

    bbc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (enq),
        .wr_data  (enq_data),
        .q_full   (q_full),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    bbc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_valid),
        .item       (q_data),
        .item_take  (q_take),
        .empty      (empty),
        .pop        (pop),
        .out_data   (out_data),
        .status     (status)
    );

    // The two errors exclude each other because the stack freezes at the first.
    a_one_error: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({status.mismatch, status.overflow}) <= 1)
        else $error("mismatch and overflow both set");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.overflow |-> (status.level == bbc_pkg::LEVEL_W'(bbc_pkg::STACK_DEPTH)))
        else $error("overflow flagged with stack not full");

    a_ovf_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_data.depth_overflow) |-> !out_data.text_valid)
        else $error("overflow result reported as valid");

endmodule

// File: tb/sv/bracket_balance_checker_unit_tb.sv
// Testbench for bracket_balance_checker_unit: directed and random texts with
// an in-bench bracket tracker that predicts each verdict beat.
// Depends on bbc_pkg and the bracket_balance_checker_unit RTL.
module bracket_balance_checker_unit_tb;

    typedef enum logic [4:0] {
        SCAN_CODE  = 5'b00001,
        SCAN_SLASH = 5'b00010,
        SCAN_LINE  = 5'b00100,
        SCAN_BLOCK = 5'b01000,
        SCAN_STAR  = 5'b10000
    } scan_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    bbc_pkg::bbc_in_t  in_data;
    logic              empty;
    logic              pop;
    bbc_pkg::bbc_out_t out_data;

    // Tracker state of the text currently being scanned.
    logic [1:0] br_stack [bbc_pkg::STACK_DEPTH];
    int         br_level;
    scan_t      scan;
    logic       mismatch_flag;
    logic       overflow_flag;

    bbc_pkg::bbc_out_t verdict_q[$];
    int                fault_count;
    int                bytes_sent;
    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_req;

    bracket_balance_checker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_data  (in_data),
        .empty    (empty),
        .pop      (pop),
        .out_data (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [7:0] bracket_char(input logic [1:0] code, input bit closing);
        case (code)
            bbc_pkg::BR_CURLY:  return closing ? bbc_pkg::CH_CLOS_CRL : bbc_pkg::CH_OPEN_CRL;
            bbc_pkg::BR_SQUARE: return closing ? bbc_pkg::CH_CLOS_SQR : bbc_pkg::CH_OPEN_SQR;
            default:            return closing ? bbc_pkg::CH_CLOS_RND : bbc_pkg::CH_OPEN_RND;
        endcase
    endfunction

    // A byte seen outside any comment: opens push, closers pop and compare.
    // Once an error is latched the stack no longer moves.
    function automatic void apply_code_char(input logic [7:0] ch);
        bit         is_open;
        bit         is_close;
        logic [1:0] code;
        is_open  = 1'b0;
        is_close = 1'b0;
        code     = bbc_pkg::BR_ROUND;
        case (ch)
            bbc_pkg::CH_OPEN_RND: is_open = 1'b1;
            bbc_pkg::CH_OPEN_CRL:
            begin
                is_open = 1'b1;
                code    = bbc_pkg::BR_CURLY;
            end
            bbc_pkg::CH_OPEN_SQR:
            begin
                is_open = 1'b1;
                code    = bbc_pkg::BR_SQUARE;
            end
            bbc_pkg::CH_CLOS_RND: is_close = 1'b1;
            bbc_pkg::CH_CLOS_CRL:
            begin
                is_close = 1'b1;
                code     = bbc_pkg::BR_CURLY;
            end
            bbc_pkg::CH_CLOS_SQR:
            begin
                is_close = 1'b1;
                code     = bbc_pkg::BR_SQUARE;
            end
            default: ;
        endcase
        if (ch == bbc_pkg::CH_SLASH)
            scan = SCAN_SLASH;
        else if (!mismatch_flag && !overflow_flag)
        begin
            if (is_open)
            begin
                if (br_level >= bbc_pkg::STACK_DEPTH)
                    overflow_flag = 1'b1;
                else
                begin
                    br_stack[br_level] = code;
                    br_level++;
                end
            end
            else if (is_close)
            begin
                if (br_level == 0)
                    mismatch_flag = 1'b1;
                else
                begin
                    br_level--;
                    if (br_stack[br_level] != code)
                        mismatch_flag = 1'b1;
                end
            end
        end
    endfunction

    // Advances the tracker by one accepted beat; returns 1 with the verdict
    // when the beat closes the text.
    function automatic bit track_byte(input bbc_pkg::bbc_in_t beat,
                                      output bbc_pkg::bbc_out_t verdict);
        logic [7:0] ch;
        ch      = beat.char_code;
        verdict = '0;
        case (scan)
            SCAN_SLASH:
            begin
                if (ch == bbc_pkg::CH_SLASH)
                    scan = SCAN_LINE;
                else if (ch == bbc_pkg::CH_STAR)
                    scan = SCAN_BLOCK;
                else
                begin
                    scan = SCAN_CODE;
                    apply_code_char(ch);
                end
            end
            SCAN_LINE:
            begin
                if (ch == bbc_pkg::CH_NEWLINE)
                    scan = SCAN_CODE;
            end
            SCAN_BLOCK:
            begin
                if (ch == bbc_pkg::CH_STAR)
                    scan = SCAN_STAR;
            end
            SCAN_STAR:
            begin
                if (ch == bbc_pkg::CH_SLASH)
                    scan = SCAN_CODE;
                else if (ch != bbc_pkg::CH_STAR)
                    scan = SCAN_BLOCK;
            end
            default: apply_code_char(ch);
        endcase
        if (!beat.last_byte)
            return 1'b0;
        verdict.text_valid     = !mismatch_flag && !overflow_flag && (br_level == 0);
        verdict.depth_overflow = overflow_flag;
        br_level      = 0;
        scan          = SCAN_CODE;
        mismatch_flag = 1'b0;
        overflow_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] ch, input logic lst);
        bbc_pkg::bbc_in_t  beat;
        bbc_pkg::bbc_out_t verdict;
        beat.char_code = ch;
        beat.last_byte = lst;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (track_byte(beat, verdict))
            verdict_q = {verdict_q, verdict};
        bytes_sent++;
    endtask

    task automatic send_bytes(input logic [7:0] txt[$]);
        int i;
        for (i = 0; i < txt.size(); i++)
            send_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic send_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // Holds the sender until every expected verdict has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rough_char();
        case ($urandom_range(11))
            0, 1, 2: return bracket_char(2'($urandom_range(2)), 1'b0);
            3, 4, 5: return bracket_char(2'($urandom_range(2)), 1'b1);
            6:       return bbc_pkg::CH_SLASH;
            7:       return bbc_pkg::CH_STAR;
            8:       return bbc_pkg::CH_NEWLINE;
            9:       return 8'($urandom_range(8'h61, 8'h7A));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_random_text();
        logic [7:0] txt[$];
        logic [1:0] open_codes[$];
        logic [1:0] code;
        int         steps;
        int         i;
        int         j;
        logic [7:0] ch;
        steps = $urandom_range(1, 24);
        if ($urandom_range(99) < 75)
        begin
            for (i = 0; i < steps; i++)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        code       = 2'($urandom_range(2));
                        open_codes = {open_codes, code};
                        txt        = {txt, bracket_char(code, 1'b0)};
                    end
                    3, 4, 5:
                    begin
                        if (open_codes.size() != 0)
                        begin
                            code = open_codes[open_codes.size() - 1];
                            open_codes.delete(open_codes.size() - 1);
                            txt = {txt, bracket_char(code, 1'b1)};
                        end
                        else
                            txt = {txt, 8'($urandom_range(8'h61, 8'h7A))};
                    end
                    6:
                    begin
                        txt = {txt, bbc_pkg::CH_SLASH, bbc_pkg::CH_SLASH};
                        for (j = $urandom_range(4); j > 0; j--)
                        begin
                            ch  = rough_char();
                            txt = {txt, (ch == bbc_pkg::CH_NEWLINE) ? bbc_pkg::CH_STAR : ch};
                        end
                        txt = {txt, bbc_pkg::CH_NEWLINE};
                    end
                    7:
                    begin
                        txt = {txt, bbc_pkg::CH_SLASH, bbc_pkg::CH_STAR};
                        for (j = $urandom_range(5); j > 0; j--)
                            txt = {txt, rough_char()};
                        for (j = $urandom_range(1, 3); j > 0; j--)
                            txt = {txt, bbc_pkg::CH_STAR};
                        txt = {txt, bbc_pkg::CH_SLASH};
                    end
                    8:
                    begin
                        // A slash that opens no comment.
                        txt = {txt, bbc_pkg::CH_SLASH, 8'($urandom_range(8'h61, 8'h7A))};
                    end
                    default:
                        txt = {txt, ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                             : 8'($urandom_range(8'h61, 8'h7A))};
                endcase
            end
            if ($urandom_range(9) != 0)
                while (open_codes.size() != 0)
                begin
                    code = open_codes[open_codes.size() - 1];
                    open_codes.delete(open_codes.size() - 1);
                    txt = {txt, bracket_char(code, 1'b1)};
                end
        end
        else
        begin
            for (i = 0; i < steps; i++)
                txt = {txt, rough_char()};
        end
        send_bytes(txt);
    endtask

    task automatic test_nesting();
        send_str("()");
        send_str("{[()]}x");
        send_str("(]");
        send_str(")");
        send_str("([{");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drained();
    endtask

    task automatic test_comments();
        send_str("(//)\n)");
        send_str("[/*]*/]");
        send_str("{/**)**/}");
        send_str("(/)");
        send_str("(/*");
        send_str("/");
        wait_drained();
    endtask

    task automatic test_depth_limit();
        int i;
        // Exactly full stack, then fully unwound.
        for (i = 0; i < bbc_pkg::STACK_DEPTH; i++)
            send_byte(bbc_pkg::CH_OPEN_CRL, 1'b0);
        for (i = 0; i < bbc_pkg::STACK_DEPTH; i++)
            send_byte(bbc_pkg::CH_CLOS_CRL, i == bbc_pkg::STACK_DEPTH - 1);
        // One push too many.
        for (i = 0; i <= bbc_pkg::STACK_DEPTH; i++)
            send_byte(bbc_pkg::CH_OPEN_RND, i == bbc_pkg::STACK_DEPTH);
        // A mismatch first freezes the stack, so no overflow is reported.
        send_byte(bbc_pkg::CH_CLOS_SQR, 1'b0);
        for (i = 0; i <= bbc_pkg::STACK_DEPTH; i++)
            send_byte(bbc_pkg::CH_OPEN_SQR, i == bbc_pkg::STACK_DEPTH);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int i;
        hold_req = 300;
        for (i = 0; i < 16; i++)
            send_byte($urandom_range(1) ? bbc_pkg::CH_SLASH : 8'h61, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int count);
        int stop_at;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        stop_at        = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_text();
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin : result_checker
        bbc_pkg::bbc_out_t want;
        int                hold_left;
        hold_left = 0;
        pop       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict beat with none expected: text_valid=%0b depth_overflow=%0b",
                           out_data.text_valid, out_data.depth_overflow);
                    fault_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (out_data.text_valid !== want.text_valid)
                    begin
                        $error("text_valid: expected %0b, got %0b",
                               want.text_valid, out_data.text_valid);
                        fault_count++;
                    end
                    if (out_data.depth_overflow !== want.depth_overflow)
                    begin
                        $error("depth_overflow: expected %0b, got %0b",
                               want.depth_overflow, out_data.depth_overflow);
                        fault_count++;
                    end
                end
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : run_tests
        int waited;
        rst_n          = 1'b0;
        push           = 1'b0;
        in_data        = '0;
        fault_count    = 0;
        bytes_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 0;
        br_level       = 0;
        scan           = SCAN_CODE;
        mismatch_flag  = 1'b0;
        overflow_flag  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_nesting();
        test_comments();
        test_depth_limit();
        test_backpressure();
        test_random_phase(0, 0, 30);
        test_random_phase(75, 0, 30);
        test_random_phase(0, 75, 30);
        test_random_phase(21, 21, 30);

        push <= 1'b0;
        waited = 0;
        while (verdict_q.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        if (verdict_q.size() != 0)
        begin
            $error("%0d verdict beats never arrived", verdict_q.size());
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            repeat (10) @(posedge clk);
            if (fault_count == 0)
                $display("DONE: 0 errors");
            else
                $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
